// ----- hdl/b64d_pkg.sv -----
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'd61;   // '='
  localparam logic [7:0] DASH_CHAR  = 8'd45;   // '-'
  localparam logic [7:0] UNDER_CHAR = 8'd95;   // '_'
  localparam logic [6:0] NO_VALUE   = 7'd64;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_CHAR = 2'd1,
    STAT_BAD_LEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] pos;    // characters seen, mod 4
    logic [5:0] left;   // undelivered bits
    logic [1:0] pad;    // '=' accepted so far
    status_t    err;    // first error of the string
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       eos;
    status_t    status;
  } dec_result_t;

  // base64url alphabet lookup; NO_VALUE for anything outside it
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] v;
    v = NO_VALUE;
    if (ch >= 8'd65 && ch <= 8'd90)        v = 7'(ch - 8'd65);
    else if (ch >= 8'd97 && ch <= 8'd122)  v = 7'(ch - 8'd71);
    else if (ch >= 8'd48 && ch <= 8'd57)   v = 7'(ch + 8'd4);
    else if (ch == DASH_CHAR)              v = 7'd62;
    else if (ch == UNDER_CHAR)             v = 7'd63;
    return v;
  endfunction

endpackage

// ----- hdl/b64d_step.sv -----
module b64d_step
  import b64d_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  in_char,
  input  logic        is_last,
  output dec_state_t  nxt,
  output dec_result_t res,
  output logic        emit
);

  logic [6:0] v;
  logic       is_pad;
  logic       have;
  logic [7:0] byte_val;
  status_t    err_n;
  logic [5:0] left_n;
  logic [1:0] pad_n;

  always_comb begin
    v        = sextet_of(in_char);
    is_pad   = (in_char == PAD_CHAR);
    have     = 1'b0;
    byte_val = '0;
    err_n    = cur.err;
    left_n   = cur.left;
    pad_n    = cur.pad;

    if (is_pad) begin
      if (cur.pos == 2'd2 && !is_last && cur.pad == 2'd0) begin
        pad_n = 2'd1;
      end else if (cur.pos == 2'd3 && is_last && cur.pad <= 2'd1) begin
        pad_n = cur.pad + 2'd1;
      end else if (cur.err == STAT_OK) begin
        err_n = STAT_BAD_CHAR;
      end
    end else if (v == NO_VALUE || cur.pad != 2'd0) begin
      if (cur.err == STAT_OK) err_n = STAT_BAD_CHAR;
    end else begin
      case (cur.pos)
        2'd0: begin
          left_n = v[5:0];
        end
        2'd1: begin
          byte_val = {cur.left, v[5:4]};
          left_n   = {2'b00, v[3:0]};
          have     = 1'b1;
        end
        2'd2: begin
          byte_val = {cur.left[3:0], v[5:2]};
          left_n   = {4'b0000, v[1:0]};
          have     = 1'b1;
        end
        default: begin
          byte_val = {cur.left[1:0], v[5:0]};
          left_n   = '0;
          have     = 1'b1;
        end
      endcase
      // lone data char in the final group
      if (is_last && cur.pos == 2'd0 && cur.err == STAT_OK) err_n = STAT_BAD_LEN;
    end

    if (is_last) begin
      nxt = '{pos: 2'd0, left: 6'd0, pad: 2'd0, err: STAT_OK};
    end else begin
      nxt = '{pos: cur.pos + 2'd1, left: left_n, pad: pad_n, err: err_n};
    end

    res.data_byte = byte_val;
    res.has_byte  = have;
    res.eos       = is_last;
    res.status    = is_last ? err_n : STAT_OK;
    emit          = have | is_last;
  end

endmodule

// ----- hdl/base64url_stream_decoder_core.sv -----
// Channel | Dir | tdata                           | tuser    | tlast
// in_     | in  | [7:0] in_char                   | -        | is_last
// out_    | out | [7:0] data_byte, [9:8] status   | has_byte | end_of_stream
//
// One character per cycle sustained while the output is not stalled: input register,
// one pass of decode logic against the state register, then the result register.
// rst_n is synchronous, active low; it clears the decode state and both valids.
// A stalled output holds the result and backs up into the input register;
// characters that produce no result still wait for a free result slot.
module base64url_stream_decoder_core
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [9:8] status, [15:10] zero
  output logic        out_tuser,  // has_byte
  output logic        out_tlast   // end_of_stream
);

  logic        in_valid_r;
  logic [7:0]  in_char_r;
  logic        in_last_r;
  dec_state_t  state_r, state_nxt;
  dec_result_t res;
  logic        emit;
  logic        out_free;
  logic        step_go;
  logic        out_valid_r;
  dec_result_t out_res_r;

  assign out_free  = !out_valid_r || out_tready;
  assign step_go   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || step_go;

  b64d_step u_step (
    .cur     (state_r),
    .in_char (in_char_r),
    .is_last (in_last_r),
    .nxt     (state_nxt),
    .res     (res),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{pos: 2'd0, left: 6'd0, pad: 2'd0, err: STAT_OK};
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (step_go) state_r <= state_nxt;
      if (out_free) out_valid_r <= step_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (step_go && emit) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.data_byte};
  assign out_tuser  = out_res_r.has_byte;
  assign out_tlast  = out_res_r.eos;

  // a result that does not close the string always carries a byte
  a_mid_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.eos |-> out_res_r.has_byte)
    else $error("non-final result without byte");

  // status only reported on the final result
  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.eos |-> out_res_r.status == STAT_OK)
    else $error("status set before end of stream");

  // state clears once the last character is processed
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(step_go && in_last_r) |-> state_r.pos == 2'd0 &&
      state_r.pad == 2'd0 && state_r.err == STAT_OK)
    else $error("state not cleared after last character");

  // an accepted '=' on a clean string can only leave the group at position three;
  // anything after it but a closing '=' flags a bad character
  a_pad_position: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pad != 2'd0 && state_r.err == STAT_OK |-> state_r.pos == 2'd3)
    else $error("pad count outside final group position");

endmodule
